FILE: hdl/dcts_pkg.sv
// Shared types, constants and arithmetic helpers for the DPCM codebook trellis search.
// Used by the search cell and by the top level; depends on nothing else.
package dcts_pkg;

	localparam int NUM_CELLS = 16;
	localparam int IDX_W     = 4;
	localparam int CNT_W     = 5;
	localparam int COST_W    = 32;
	localparam int VAL_W     = 8;
	localparam int CODE_W    = 9;
	localparam int SQ_W      = 16;
	localparam int CFG_W     = 63;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CODE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CODES_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CODES_MID  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CODES_HIGH = 2'd3;

	// Decoded start value and the saturation limit of an accumulated cost.
	localparam logic [VAL_W-1:0]  START_VALUE = 8'd128;
	localparam logic [VAL_W-1:0]  VALUE_MAX   = 8'd255;
	localparam logic [COST_W-1:0] COST_MAX    = 32'hFFFF_FFFF;

	// One survivor as it travels round the ring of cells.
	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic [VAL_W-1:0]  value;
		logic [IDX_W-1:0]  idx;
	} ring_t;

	// Commands that the sequencer broadcasts to every cell.
	typedef struct packed {
		logic init;    // start every survivor from the first sample
		logic load;    // copy own survivor into the ring register
		logic shift;   // take the neighbour's ring register
		logic run;     // score the survivor now in the ring register
		logic commit;  // replace own survivor by the best candidate
	} cell_ctrl_t;

	// Adds a signed code to a decoded value and clamps the result to 0..255.
	function automatic logic [VAL_W-1:0] clamp_add(input logic [VAL_W-1:0] v,
			input logic signed [CODE_W-1:0] c);
		logic signed [CODE_W:0] s;
		s = $signed({2'b00, v}) + $signed({c[CODE_W-1], c});
		if (s > $signed({2'b00, VALUE_MAX}))
			return VALUE_MAX;
		else if (s < 0)
			return '0;
		else
			return s[VAL_W-1:0];
	endfunction

	// Squared difference of two 8-bit values.
	function automatic logic [SQ_W-1:0] sq_err(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b);
		logic [VAL_W-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return {8'd0, d} * {8'd0, d};
	endfunction

	// Cost accumulation that sticks at the all-ones limit.
	function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
			input logic [SQ_W-1:0] b);
		logic [COST_W:0] s;
		s = {1'b0, a} + {17'd0, b};
		return s[COST_W] ? COST_MAX : s[COST_W-1:0];
	endfunction

endpackage

FILE: hdl/dcts_cell.sv
// One codeword cell of the trellis ring: holds the survivor of its codeword and
// picks the cheapest predecessor as the survivors pass by. Depends on dcts_pkg.
module dcts_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dcts_pkg::cell_ctrl_t                ctrl,
	input  logic [dcts_pkg::VAL_W-1:0]          x,
	input  logic signed [dcts_pkg::CODE_W-1:0]  code,
	input  logic [dcts_pkg::IDX_W-1:0]          index,
	input  logic [dcts_pkg::CNT_W-1:0]          count,
	input  dcts_pkg::ring_t                     ring_in,
	output dcts_pkg::ring_t                     ring_out
);
	import dcts_pkg::*;

	logic [COST_W-1:0] surv_cost_q;
	logic [VAL_W-1:0]  surv_value_q;
	ring_t             ring_q;
	ring_t             cand_s1;
	logic              cand_vld_s1;
	ring_t             best_q;
	logic              best_vld_q;

	logic              active;
	logic [VAL_W-1:0]  init_value;
	logic [COST_W-1:0] init_cost;
	logic [VAL_W-1:0]  cand_value;
	logic [COST_W-1:0] cand_cost;
	logic              cand_ok;
	logic              better;

	assign ring_out = ring_q;
	assign active   = ({1'b0, index} < count);

	// Starting survivor for the first sample of a sequence.
	assign init_value = clamp_add(START_VALUE, code);
	assign init_cost  = {16'd0, sq_err(x, init_value)};

	// Cost of extending the passing survivor by this cell's codeword.
	assign cand_value = clamp_add(ring_q.value, code);
	assign cand_cost  = sat_add(ring_q.cost, sq_err(x, cand_value));
	assign cand_ok    = ctrl.run && ({1'b0, ring_q.idx} < count);

	// A lower cost wins; on a tie the lower predecessor index wins.
	assign better = !best_vld_q || (cand_s1.cost < best_q.cost) ||
		((cand_s1.cost == best_q.cost) && (cand_s1.idx < best_q.idx));

	// Survivor, ring and candidate registers. A cell outside the codewords in
	// use keeps its survivor untouched.
	always_ff @(posedge clk) begin
		if (ctrl.init && active) begin
			surv_cost_q  <= init_cost;
			surv_value_q <= init_value;
		end else if (ctrl.commit && active) begin
			surv_cost_q  <= best_q.cost;
			surv_value_q <= best_q.value;
		end
		if (ctrl.load) begin
			ring_q <= '{cost: surv_cost_q, value: surv_value_q, idx: index};
		end else if (ctrl.shift) begin
			ring_q <= ring_in;
		end
		cand_s1 <= '{cost: cand_cost, value: cand_value, idx: ring_q.idx};
		if (cand_vld_s1 && better) begin
			best_q <= cand_s1;
		end
	end

	// Candidate and best-so-far qualifiers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_vld_s1 <= 1'b0;
			best_vld_q  <= 1'b0;
		end else begin
			cand_vld_s1 <= cand_ok;
			if (ctrl.load)
				best_vld_q <= 1'b0;
			else if (cand_vld_s1)
				best_vld_q <= 1'b1;
		end
	end

endmodule

FILE: hdl/dpcm_codebook_trellis_search.sv
// Top level of the DPCM codebook trellis search: configuration registers,
// sequencer, the ring of sixteen cells and the result register. Depends on dcts_pkg, dcts_cell.
//
// One sample is taken at a time; in_stall stays high until its work is done.
// A first sample only sets up the survivors. Any other sample loads the ring,
// then the survivors rotate once round the ring of 16 cells, one position per cycle,
// so that every codeword cell scores every predecessor, followed by a
// pipeline drain and a commit. A last sample adds a step to load the ring,
// a pass in which the survivors rotate once more past cell 0 to find the
// smallest cost, and a step to hand that cost to the result register,
// repeated while the register still holds an earlier result. A finished
// result waits in that register while the next sample is accepted.
module dpcm_codebook_trellis_search (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [dcts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dcts_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        sample,
	input  logic                              first,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [31:0]                       min_error
);
	import dcts_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_INIT   = 9'b000000010,
		ST_LOAD   = 9'b000000100,
		ST_RUN    = 9'b000001000,
		ST_DRAIN  = 9'b000010000,
		ST_COMMIT = 9'b000100000,
		ST_MLOAD  = 9'b001000000,
		ST_SCAN   = 9'b010000000,
		ST_EMIT   = 9'b100000000
	} state_t;

	state_t               state_q;
	logic [IDX_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     code_count_q;
	logic [CFG_W-1:0]     codes_low_q;
	logic [CFG_W-1:0]     codes_mid_q;
	logic [17:0]          codes_high_q;
	logic [VAL_W-1:0]     x_q;
	logic                 last_q;
	logic [COST_W-1:0]    min_q;
	logic                 min_vld_q;
	logic                 out_valid_q;
	logic [COST_W-1:0]    out_data_q;

	logic                 in_xfer;
	logic                 out_free;
	logic [CNT_W-1:0]     count;
	cell_ctrl_t           ctrl;
	logic signed [CODE_W-1:0] codes [NUM_CELLS];
	ring_t                rings [NUM_CELLS];
	ring_t                head;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign min_error = out_data_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Codeword count in use, with zero taken as one and large values as sixteen.
	always_comb begin
		if (code_count_q == '0)
			count = 5'd1;
		else if (code_count_q > 5'(NUM_CELLS))
			count = 5'(NUM_CELLS);
		else
			count = code_count_q;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_count_q <= 5'd1;
			codes_low_q  <= '0;
			codes_mid_q  <= '0;
			codes_high_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_CODE_COUNT: code_count_q <= cfg_data[CNT_W-1:0];
				REG_CODES_LOW:  codes_low_q  <= cfg_data;
				REG_CODES_MID:  codes_mid_q  <= cfg_data;
				REG_CODES_HIGH: codes_high_q <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	// Command broadcast to the cells.
	always_comb begin
		ctrl        = '0;
		ctrl.init   = (state_q == ST_INIT);
		ctrl.load   = (state_q == ST_LOAD) || (state_q == ST_MLOAD);
		ctrl.shift  = (state_q == ST_RUN) || (state_q == ST_SCAN);
		ctrl.run    = (state_q == ST_RUN);
		ctrl.commit = (state_q == ST_COMMIT);
	end

	// The ring of cells; each cell takes its neighbour's ring register while the ring shifts.
	for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
		localparam int NXT = (j + 1) % NUM_CELLS;
		if (j < 7) begin : g_low
			assign codes[j] = $signed(codes_low_q[9*j +: CODE_W]);
		end else if (j < 14) begin : g_mid
			assign codes[j] = $signed(codes_mid_q[9*(j-7) +: CODE_W]);
		end else begin : g_high
			assign codes[j] = $signed(codes_high_q[9*(j-14) +: CODE_W]);
		end
		dcts_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.x        (x_q),
			.code     (codes[j]),
			.index    (IDX_W'(j)),
			.count    (count),
			.ring_in  (rings[NXT]),
			.ring_out (rings[j])
		);
	end

	assign head = rings[0];

	// Captured sample and the running minimum of the final scan.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_q     <= sample;
			last_q  <= last;
		end
		if ((state_q == ST_SCAN) && ({1'b0, head.idx} < count) &&
				(!min_vld_q || (head.cost < min_q))) begin
			min_q <= head.cost;
		end
		if ((state_q == ST_EMIT) && out_free) begin
			out_data_q <= min_q;
		end
	end

	// Sequencer and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			min_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer)
						state_q <= first ? ST_INIT : ST_LOAD;
				end
				ST_INIT: begin
					state_q <= last_q ? ST_MLOAD : ST_IDLE;
				end
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IDX_W'(NUM_CELLS - 1))
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					state_q <= last_q ? ST_MLOAD : ST_IDLE;
				end
				ST_MLOAD: begin
					cnt_q     <= '0;
					min_vld_q <= 1'b0;
					state_q   <= ST_SCAN;
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if ({1'b0, head.idx} < count)
						min_vld_q <= 1'b1;
					if (cnt_q == IDX_W'(NUM_CELLS - 1))
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
